// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge, disabled in reset
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/ibh_pkg.sv =====
// Package for the indexed binary heap: sizes, opcodes and status codes.
// No dependencies.
`default_nettype none
package ibh_pkg;
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 8;
  localparam int CNT_W_DEF      = $clog2(CAPACITY_DEF + 1);
  localparam int OPC_W = 2;
  localparam int STS_W = 2;
  localparam logic [OPC_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPC_W-1:0] OP_POP  = 2'd1;
  localparam logic [OPC_W-1:0] OP_TEST = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP  = 2'd3;
  localparam logic [STS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STS_W-1:0] ST_DUP  = 2'd3;
endpackage
`default_nettype wire

// ===== sv/ibh_if.sv =====
// Valid/ready channel interfaces for the heap's input, result and config ports.
// Depends on ibh_pkg.
`default_nettype none
interface ibh_in_if #(parameter int VALUE_BITS = ibh_pkg::VALUE_BITS_DEF);
  logic valid;
  logic ready;
  logic [ibh_pkg::OPC_W-1:0] opcode;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

interface ibh_out_if #(parameter int VALUE_BITS = ibh_pkg::VALUE_BITS_DEF,
                       parameter int CNT_W = ibh_pkg::CNT_W_DEF);
  logic valid;
  logic ready;
  logic [VALUE_BITS-1:0] top_value;
  logic found;
  logic [ibh_pkg::STS_W-1:0] status;
  logic [CNT_W-1:0] count;
  logic is_empty;
  modport source (output valid, top_value, found, status, count, is_empty, input ready);
  modport sink (input valid, top_value, found, status, count, is_empty, output ready);
endinterface

interface ibh_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/indexed_binary_heap.sv =====
// Indexed binary heap priority queue: top level with sequencer and heap store.
// Depends on ibh_pkg, ibh_if and assert_macros.svh.
//
// Use: in_ch (sink) takes an item {opcode, value}: push, pop, test or no-op.
// out_ch (source) returns one result item per input item: popped value,
// found flag, status, count after the operation and empty flag. cfg_ch
// (sink) writes top_is_larger (1 = largest on top, reset 1); taken only
// while idle, and the stored heap is kept as it is under a new order.
// One item at a time: in_ch.ready is low from accept until the result has
// left. Test, no-op and refused items go from the decode state straight to
// the result. Push: the value is compared with its parent one level at a
// time on the way up, with one more step when it lands at the root. Pop:
// the top is read, the last entry becomes the moving value, and at each
// level it is compared with its children until it rests or reaches a leaf.
// Steps are set by the single read port on the heap store and the one
// shared compare unit. A stalled receiver holds the result and the block
// takes nothing new. Reset clears the presence bitmap, the count and the
// sequencer; the heap store needs no clearing as only slots below the count
// are read. No value-to-slot map is kept: no operation reads one.
`default_nettype none
`include "assert_macros.svh"
module indexed_binary_heap #(
  parameter int CAPACITY   = ibh_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ibh_pkg::VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ibh_in_if.sink    in_ch,
  ibh_out_if.source out_ch,
  ibh_cfg_if.sink   cfg_ch
);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SPAN   = 1 << VALUE_BITS;
  localparam int KID_W  = SLOT_W + 2;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_UPCMP = 4'd2,
    S_PLACE = 4'd3, S_POPTOP = 4'd4, S_POPLAST = 4'd5, S_DNL = 4'd6,
    S_DNR = 4'd7, S_DNCMP = 4'd8, S_DNSW = 4'd9, S_OUT = 4'd10;

  logic [3:0] st_r;
  logic order_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SPAN-1:0] present_r;
  logic [ibh_pkg::OPC_W-1:0] op_r;
  logic [VALUE_BITS-1:0] val_r;
  // pos_r: the hole the moving value cur_r will fill; par_r: its parent
  logic [SLOT_W-1:0] pos_r, par_r, kid_r, best_r;
  logic [VALUE_BITS-1:0] cur_r, kidv_r, bestv_r, top_r;
  logic has_r;
  logic [ibh_pkg::STS_W-1:0] sts_r;
  logic found_r;

  // heap store: one write and one registered read per cycle
  logic [VALUE_BITS-1:0] heap_mem [CAPACITY];
  logic [SLOT_W-1:0] rd_addr;
  logic [VALUE_BITS-1:0] rd_r;
  logic hw_en;
  logic [SLOT_W-1:0] hw_addr;
  logic [VALUE_BITS-1:0] hw_data;

  always_ff @(posedge clk) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    rd_r <= heap_mem[rd_addr];
  end

  // shared compare unit: a ranks above b
  logic [VALUE_BITS-1:0] ca, cb;
  logic above;
  assign above = order_r ? (ca > cb) : (ca < cb);

  always_comb begin
    ca = cur_r; cb = rd_r;
    case (st_r)
      S_DNCMP: begin
        ca = rd_r; cb = kidv_r;
      end
      S_DNSW: begin
        ca = bestv_r; cb = cur_r;
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.top_value = top_r;
  assign out_ch.found = found_r;
  assign out_ch.status = sts_r;
  assign out_ch.count = cnt_r;
  assign out_ch.is_empty = (cnt_r == '0);

  logic push_ok, pop_ok;
  logic [ibh_pkg::STS_W-1:0] dec_sts;
  logic [CNT_W-1:0] last_c;
  logic [SLOT_W-1:0] up_par, dn_par, right_c;
  logic [SLOT_W:0] kid_c;
  logic kid_in, right_in;

  assign push_ok = (op_r == ibh_pkg::OP_PUSH) && (cnt_r != CNT_W'(CAPACITY))
                   && !present_r[val_r];
  assign pop_ok  = (op_r == ibh_pkg::OP_POP) && (cnt_r != '0);
  assign last_c  = cnt_r - CNT_W'(1);
  // parent of the new slot at cnt_r, and parent of par_r
  assign up_par  = SLOT_W'(last_c >> 1);
  assign dn_par  = SLOT_W'((par_r - SLOT_W'(1)) >> 1);
  // children of pos_r, checked against the live count
  assign kid_c    = {pos_r, 1'b1};
  assign kid_in   = KID_W'(kid_c) < KID_W'(cnt_r);
  assign right_in = (KID_W'(kid_c) + KID_W'(1)) < KID_W'(cnt_r);
  assign right_c  = SLOT_W'(kid_r + SLOT_W'(1));

  always_comb begin
    dec_sts = ibh_pkg::ST_OK;
    if (op_r == ibh_pkg::OP_PUSH) begin
      if (cnt_r == CNT_W'(CAPACITY)) dec_sts = ibh_pkg::ST_FULL;
      else if (present_r[val_r]) dec_sts = ibh_pkg::ST_DUP;
    end else if (op_r == ibh_pkg::OP_POP && cnt_r == '0) begin
      dec_sts = ibh_pkg::ST_EMPTY;
    end
  end

  // store port control: displaced values move into the hole, cur_r is
  // written once where it comes to rest
  always_comb begin
    rd_addr = '0;
    hw_en = 1'b0; hw_addr = pos_r; hw_data = cur_r;
    case (st_r)
      S_DEC: begin
        if (push_ok && cnt_r == '0) begin
          hw_en = 1'b1; hw_addr = '0; hw_data = val_r;
        end
        rd_addr = push_ok ? up_par : '0;
      end
      S_UPCMP: begin
        hw_en = 1'b1;
        hw_data = above ? rd_r : cur_r;
        rd_addr = dn_par;
      end
      S_PLACE: hw_en = 1'b1;
      S_POPTOP: rd_addr = last_c[SLOT_W-1:0];
      S_DNL: begin
        hw_en = !kid_in;
        rd_addr = kid_c[SLOT_W-1:0];
      end
      S_DNR: rd_addr = right_c;
      S_DNSW: begin
        hw_en = 1'b1;
        hw_data = above ? bestv_r : cur_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      order_r <= 1'b1;
      cnt_r <= '0;
      present_r <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) order_r <= cfg_ch.data;
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r <= in_ch.opcode; val_r <= in_ch.value;
            st_r <= S_DEC;
          end
        end
        S_DEC: begin
          top_r <= '0;
          found_r <= (op_r == ibh_pkg::OP_TEST) && present_r[val_r];
          sts_r <= dec_sts;
          if (push_ok) begin
            present_r[val_r] <= 1'b1;
            cnt_r <= cnt_r + CNT_W'(1);
            pos_r <= cnt_r[SLOT_W-1:0];
            par_r <= up_par;
            cur_r <= val_r;
            // first value goes straight to the root
            st_r <= (cnt_r == '0) ? S_OUT : S_UPCMP;
          end else if (pop_ok) begin
            st_r <= S_POPTOP;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_UPCMP: begin
          // rd_r holds the parent value; one level per cycle
          if (above) begin
            pos_r <= par_r;
            par_r <= dn_par;
            if (par_r == '0) st_r <= S_PLACE;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_PLACE: st_r <= S_OUT;
        S_POPTOP: begin
          top_r <= rd_r;
          present_r[rd_r] <= 1'b0;
          cnt_r <= last_c;
          st_r <= S_POPLAST;
        end
        S_POPLAST: begin
          // last entry becomes the moving value, hole at the root
          cur_r <= rd_r;
          pos_r <= '0;
          st_r <= (cnt_r == '0) ? S_OUT : S_DNL;
        end
        S_DNL: begin
          kid_r <= kid_c[SLOT_W-1:0];
          has_r <= right_in;
          st_r <= kid_in ? S_DNR : S_OUT;
        end
        S_DNR: begin
          kidv_r <= rd_r; best_r <= kid_r;
          st_r <= S_DNCMP;
        end
        S_DNCMP: begin
          // rd_r holds the right child when there is one
          if (has_r && above) begin
            best_r <= right_c; bestv_r <= rd_r;
          end else begin
            bestv_r <= kidv_r;
          end
          st_r <= S_DNSW;
        end
        S_DNSW: begin
          if (above) begin
            pos_r <= best_r;
            st_r <= S_DNL;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `AST_IMP(a_busy_not_ready, clk, rst_n, st_r != S_IDLE, !in_ch.ready)
  `AST_IMP(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `AST_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(top_r))
endmodule
`default_nettype wire
